### rtl/two_way_branch_history_and_target_buffer_core_assert.svh
// Assertion macros used by the predictor core.
`ifndef TWO_WAY_BRANCH_HISTORY_AND_TARGET_BUFFER_CORE_ASSERT_SVH
`define TWO_WAY_BRANCH_HISTORY_AND_TARGET_BUFFER_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define TWBHTB_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("predictor assertion failed");

// Check a consequence in the cycle after its antecedent.
`define TWBHTB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("predictor assertion failed");

`endif

### rtl/twbhtb_pkg.sv
package twbhtb_pkg;

  localparam int INDEX_BITS = 6;
  localparam int NUM_SETS   = 1 << INDEX_BITS;
  localparam int TAG_BITS   = 30 - INDEX_BITS;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [1:0] CNT_STRONG_NT = 2'b00;
  localparam logic [1:0] CNT_WEAK_NT   = 2'b01;
  localparam logic [1:0] CNT_WEAK_T    = 2'b10;
  localparam logic [1:0] CNT_STRONG_T  = 2'b11;

  typedef struct packed {
    logic [1:0]          cnt;
    logic [TAG_BITS-1:0] tag;
    logic [31:0]         target;
  } way_t;

  typedef struct packed {
    way_t w1;
    way_t w0;
  } set_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] pc;
    logic [31:0] disp;
    logic        taken;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        predict_taken;
    logic [31:0] predicted_target;
  } rsp_t;

  typedef struct packed {
    logic [1:0] valid;
    logic       older;
  } ctl_t;

  function automatic logic [1:0] step_counter(input logic [1:0] c, input logic t);
    logic [1:0] r;
    r = c;
    case (c)
      CNT_STRONG_NT: r = t ? CNT_WEAK_NT  : CNT_STRONG_NT;
      CNT_WEAK_NT:   r = t ? CNT_WEAK_T   : CNT_STRONG_NT;
      CNT_WEAK_T:    r = t ? CNT_STRONG_T : CNT_WEAK_NT;
      CNT_STRONG_T:  r = t ? CNT_STRONG_T : CNT_WEAK_T;
      default:       r = c;
    endcase
    return r;
  endfunction

endpackage

### rtl/twbhtb_ram.sv
module twbhtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/twbhtb_resolve.sv
module twbhtb_resolve (
  input  twbhtb_pkg::req_t req,
  input  twbhtb_pkg::ctl_t ctl,
  input  twbhtb_pkg::set_t rd,
  output twbhtb_pkg::rsp_t rsp,
  output twbhtb_pkg::ctl_t ctl_next,
  output twbhtb_pkg::set_t wr,
  output logic             we
);

  logic [twbhtb_pkg::TAG_BITS-1:0] tag;
  logic                            m0;
  logic                            m1;
  twbhtb_pkg::way_t                sel;
  twbhtb_pkg::way_t                fresh;
  logic                            victim;

  assign tag = req.pc[31:twbhtb_pkg::INDEX_BITS+2];
  assign m0  = ctl.valid[0] && (rd.w0.tag == tag);
  assign m1  = ctl.valid[1] && (rd.w1.tag == tag);
  assign sel = m0 ? rd.w0 : rd.w1;
  assign we  = (req.cmd == twbhtb_pkg::CMD_UPDATE);

  always_comb begin
    fresh.cnt    = req.taken ? twbhtb_pkg::CNT_WEAK_T : twbhtb_pkg::CNT_WEAK_NT;
    fresh.tag    = tag;
    fresh.target = req.pc + req.disp;

    if (!ctl.valid[0]) begin
      victim = 1'b0;
    end else if (!ctl.valid[1]) begin
      victim = 1'b1;
    end else begin
      victim = ctl.older;
    end

    rsp.hit              = m0 || m1;
    rsp.predict_taken    = 1'b0;
    rsp.predicted_target = '0;
    wr                   = rd;
    ctl_next             = ctl;

    if (req.cmd == twbhtb_pkg::CMD_LOOKUP) begin
      rsp.predict_taken    = (m0 || m1) && sel.cnt[1];
      rsp.predicted_target = ((m0 || m1) && sel.cnt[1]) ? sel.target : req.pc;
    end else if (m0) begin
      wr.w0.cnt = twbhtb_pkg::step_counter(rd.w0.cnt, req.taken);
    end else if (m1) begin
      wr.w1.cnt = twbhtb_pkg::step_counter(rd.w1.cnt, req.taken);
    end else begin
      if (victim) begin
        wr.w1 = fresh;
      end else begin
        wr.w0 = fresh;
      end
      ctl_next.valid[victim] = 1'b1;
      ctl_next.older         = ~victim;
    end
  end

endmodule

### rtl/two_way_branch_history_and_target_buffer_core.sv
// Two-way set-associative branch predictor with a target buffer.
// Request channel s_*: tuser carries the command (0 lookup, 1 update);
// tdata carries pc, the signed displacement and the resolved taken bit.
// Response channel m_*: one response per request, in order, carrying
// hit, predict_taken and predicted_target (both zero for an update).
// A request is accepted in ST_IDLE, which reads its set from the
// synchronous entry RAM; ST_LOOK then compares both ways, writes the
// modified set back and loads the response register, and waits there
// while a full output register is not taken. The single RAM read port and
// the read-modify-write of a set admit no request until the last is done.
// A response waiting in the output register does not block the next
// accept; if the receiver still stalls when the following response is
// ready, the block holds that request and stops accepting.
// Reset clears all valid bits and replacement bits at once, so the block
// takes requests as soon as reset is released; counters, tags and
// targets are never cleared and are read only behind a valid bit.
`include "two_way_branch_history_and_target_buffer_core_assert.svh"

module two_way_branch_history_and_target_buffer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // pc[31:0], disp[63:32], taken[64], zero[71:65]
  input  logic [0:0]  s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // hit[0], predict_taken[1], predicted_target[33:2], zero[39:34]
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  localparam int IW = twbhtb_pkg::INDEX_BITS;

  state_t                  state;
  twbhtb_pkg::req_t        req;
  logic [1:0]              way_valid [twbhtb_pkg::NUM_SETS];
  logic                    older_way [twbhtb_pkg::NUM_SETS];
  logic [IW-1:0]           req_set;
  logic [IW-1:0]           raddr;
  twbhtb_pkg::set_t        rd;
  twbhtb_pkg::set_t        wr;
  twbhtb_pkg::ctl_t        ctl;
  twbhtb_pkg::ctl_t        ctl_next;
  twbhtb_pkg::rsp_t        rsp;
  logic                    upd;
  logic                    done;
  logic                    ram_we;
  logic                    accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign req_set  = req.pc[IW+1:2];
  assign raddr    = (state == ST_IDLE) ? s_tdata[IW+1:2] : req_set;
  assign done     = (state == ST_LOOK) && (!m_tvalid || m_tready);
  assign ram_we   = done && upd;
  assign ctl.valid = way_valid[req_set];
  assign ctl.older = older_way[req_set];

  twbhtb_ram #(
    .WIDTH($bits(twbhtb_pkg::set_t)),
    .DEPTH(twbhtb_pkg::NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_set),
    .wdata (wr),
    .raddr (raddr),
    .rdata (rd)
  );

  twbhtb_resolve u_resolve (
    .req      (req),
    .ctl      (ctl),
    .rd       (rd),
    .rsp      (rsp),
    .ctl_next (ctl_next),
    .wr       (wr),
    .we       (upd)
  );

  // hold the request while it is resolved
  always_ff @(posedge clk) begin
    if (accept) begin
      req.cmd   <= s_tuser[0];
      req.pc    <= s_tdata[31:0];
      req.disp  <= s_tdata[63:32];
      req.taken <= s_tdata[64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < twbhtb_pkg::NUM_SETS; i++) begin
        way_valid[i] <= 2'b00;
        older_way[i] <= 1'b0;
      end
    end else if (ram_we) begin
      way_valid[req_set] <= ctl_next.valid;
      older_way[req_set] <= ctl_next.older;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {6'd0, rsp.predicted_target, rsp.predict_taken, rsp.hit};
    end
  end

  `TWBHTB_ASSERT_NOW(a_we_in_look, ram_we, (state == ST_LOOK) && (req.cmd == twbhtb_pkg::CMD_UPDATE))
  `TWBHTB_ASSERT_NEXT(a_accept_look, accept, (state == ST_LOOK) && !s_tready)
  `TWBHTB_ASSERT_NEXT(a_done_resp, done, m_tvalid && (state == ST_IDLE))
  `TWBHTB_ASSERT_NEXT(a_upd_zero, done && (req.cmd == twbhtb_pkg::CMD_UPDATE), m_tdata[33:1] == 33'd0)
  `TWBHTB_ASSERT_NEXT(a_miss_pc, done && (req.cmd == twbhtb_pkg::CMD_LOOKUP) && !rsp.hit, (m_tdata[33:2] == $past(req.pc)) && !m_tdata[1])

endmodule

### tb/tb_top.sv
module tb_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 650;
  localparam int POOL_SIZE     = 24;
  localparam int HOT_SETS      = 8;
  localparam int DIRECTED_ROWS = 24;

  typedef struct packed {
    logic        cmd;
    logic [31:0] pc;
    logic [31:0] disp;
    logic        taken;
    logic        typed;
    logic        hit;
    logic        predict_taken;
    logic [31:0] target;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  logic [1:0]                      bp_valid  [twbhtb_pkg::NUM_SETS];
  logic [1:0]                      bp_cnt    [twbhtb_pkg::NUM_SETS][2];
  logic [twbhtb_pkg::TAG_BITS-1:0] bp_tag    [twbhtb_pkg::NUM_SETS][2];
  logic [31:0]                     bp_target [twbhtb_pkg::NUM_SETS][2];
  logic                            bp_older  [twbhtb_pkg::NUM_SETS];

  twbhtb_pkg::rsp_t predicted_rsp_q[$];
  twbhtb_pkg::rsp_t head_rsp;
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               ready_run = 0;
  logic [31:0]      pc_pool   [POOL_SIZE];
  int               pool_bias [POOL_SIZE];

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_1000, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_1000, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_2000, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_2000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_3000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_3000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'h0000_4000, 32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_2000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'hFFFF_FFFC, 32'h0000_0004, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'h0000_00FC, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{twbhtb_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000}
  };

  two_way_branch_history_and_target_buffer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("ERROR at cycle %0d: %s: expected %h, got %h", cycle_count, what, want, got);
    mismatch_count++;
  endtask

  task automatic predict_branch(input logic cmd, input logic [31:0] pc,
                                input logic [31:0] disp, input logic taken,
                                output twbhtb_pkg::rsp_t rsp);
    logic [twbhtb_pkg::INDEX_BITS-1:0] set_idx;
    logic [twbhtb_pkg::TAG_BITS-1:0]   tag;
    int                                w;
    int                                victim;
    set_idx = pc[twbhtb_pkg::INDEX_BITS+1:2];
    tag     = pc[31:twbhtb_pkg::INDEX_BITS+2];
    w = -1;
    if (bp_valid[set_idx][0] && bp_tag[set_idx][0] == tag) begin
      w = 0;
    end else if (bp_valid[set_idx][1] && bp_tag[set_idx][1] == tag) begin
      w = 1;
    end
    rsp.hit              = (w >= 0);
    rsp.predict_taken    = 1'b0;
    rsp.predicted_target = '0;
    if (cmd == twbhtb_pkg::CMD_LOOKUP) begin
      if (w >= 0 && bp_cnt[set_idx][w][1]) begin
        rsp.predict_taken    = 1'b1;
        rsp.predicted_target = bp_target[set_idx][w];
      end else begin
        rsp.predicted_target = pc;
      end
    end else if (w >= 0) begin
      if (taken) begin
        if (bp_cnt[set_idx][w] != twbhtb_pkg::CNT_STRONG_T)
          bp_cnt[set_idx][w] = bp_cnt[set_idx][w] + 2'd1;
      end else begin
        if (bp_cnt[set_idx][w] != twbhtb_pkg::CNT_STRONG_NT)
          bp_cnt[set_idx][w] = bp_cnt[set_idx][w] - 2'd1;
      end
    end else begin
      if (!bp_valid[set_idx][0]) begin
        victim = 0;
      end else if (!bp_valid[set_idx][1]) begin
        victim = 1;
      end else begin
        victim = int'(bp_older[set_idx]);
      end
      bp_valid[set_idx][victim]  = 1'b1;
      bp_cnt[set_idx][victim]    = taken ? twbhtb_pkg::CNT_WEAK_T : twbhtb_pkg::CNT_WEAK_NT;
      bp_tag[set_idx][victim]    = tag;
      bp_target[set_idx][victim] = pc + disp;
      bp_older[set_idx]          = (victim == 0);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic cmd, input logic [31:0] pc,
                              input logic [31:0] disp, input logic taken,
                              input logic typed, input twbhtb_pkg::rsp_t want);
    twbhtb_pkg::rsp_t predicted;
    int               gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, taken, disp, pc};
    do @(posedge clk); while (!s_tready);
    predict_branch(cmd, pc, disp, taken, predicted);
    predicted_rsp_q.push_back(typed ? want : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (ready_run == 0) begin
      m_tready  <= ($urandom_range(0, 2) != 0);
      ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 4);
    end else begin
      ready_run = ready_run - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_rsp_q.size() == 0) begin
        report_mismatch("response with no request pending", 32'h0, m_tdata[33:2]);
      end else begin
        head_rsp = predicted_rsp_q.pop_front();
        if (m_tdata[0] !== head_rsp.hit)
          report_mismatch("hit", {31'b0, head_rsp.hit}, {31'b0, m_tdata[0]});
        if (m_tdata[1] !== head_rsp.predict_taken)
          report_mismatch("predict_taken", {31'b0, head_rsp.predict_taken},
                          {31'b0, m_tdata[1]});
        if (m_tdata[33:2] !== head_rsp.predicted_target)
          report_mismatch("predicted_target", head_rsp.predicted_target, m_tdata[33:2]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    twbhtb_pkg::rsp_t                  want;
    logic [twbhtb_pkg::INDEX_BITS-1:0] hot [HOT_SETS];
    logic [31:0]                       pc;
    logic                              cmd;
    logic                              taken;
    int                                pick;
    for (int s = 0; s < twbhtb_pkg::NUM_SETS; s++) begin
      bp_valid[s] = 2'b00;
      bp_older[s] = 1'b0;
    end
    for (int h = 0; h < HOT_SETS; h++) hot[h] = twbhtb_pkg::INDEX_BITS'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pc_pool[i] = $urandom;
      pc_pool[i][twbhtb_pkg::INDEX_BITS+1:2] = hot[i % HOT_SETS];
      pool_bias[i] = (i % 3 == 0) ? 50 : ((i % 3 == 1) ? 90 : 10);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      want.hit              = directed_rows[r].hit;
      want.predict_taken    = directed_rows[r].predict_taken;
      want.predicted_target = directed_rows[r].target;
      send_request(directed_rows[r].cmd, directed_rows[r].pc, directed_rows[r].disp,
                   directed_rows[r].taken, directed_rows[r].typed, want);
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) begin
        // hold until the response stream drains
        s_tvalid <= 1'b0;
        do @(posedge clk); while (predicted_rsp_q.size() != 0);
      end
      pick  = $urandom_range(0, POOL_SIZE - 1);
      pc    = ($urandom_range(0, 3) != 0) ? pc_pool[pick] : $urandom;
      taken = ($urandom_range(0, 99) < pool_bias[pick]);
      cmd   = ($urandom_range(0, 99) < 55) ? twbhtb_pkg::CMD_UPDATE : twbhtb_pkg::CMD_LOOKUP;
      send_request(cmd, pc, $urandom, taken, 1'b0, want);
    end

    s_tvalid <= 1'b0;
    while (predicted_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### two_way_branch_history_and_target_buffer_core.f
+incdir+rtl
rtl/twbhtb_pkg.sv
rtl/twbhtb_ram.sv
rtl/twbhtb_resolve.sv
rtl/two_way_branch_history_and_target_buffer_core.sv
tb/tb_top.sv
